>>> design/sld_pkg.sv
package sld_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int INDEX_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [BYTE_WIDTH-1:0] SYNC_FIRST_RESET  = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] SYNC_SECOND_RESET = 8'h83;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_SECOND = 8'd1;

   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  out_byte;
      logic [INDEX_WIDTH-1:0] payload_index;
      logic                   frame_end;
      logic                   frame_ok;
   } result_type;

   typedef struct packed {
      logic       load;
      result_type result;
   } result_push_type;

endpackage

>>> design/sld_parser.sv
module sld_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sld_pkg::BYTE_WIDTH-1:0]     sync_first,
   input  logic [sld_pkg::BYTE_WIDTH-1:0]     sync_second,
   input  logic                               in_valid,
   input  logic [sld_pkg::BYTE_WIDTH-1:0]     in_byte,
   input  logic                               out_free,
   output logic                               take,
   output sld_pkg::result_push_type           push
);

   sld_pkg::phase_type                  phase_ff, phase_in;
   logic [sld_pkg::INDEX_WIDTH-1:0]     length_ff, length_in;
   logic [sld_pkg::INDEX_WIDTH-1:0]     count_ff, count_in;
   logic [sld_pkg::BYTE_WIDTH-1:0]      sum_ff, sum_in;
   logic [sld_pkg::INDEX_WIDTH-1:0]     count_next;
   logic [sld_pkg::INDEX_WIDTH-1:0]     length_full;
   logic                                emits;

   assign emits       = phase_ff inside {sld_pkg::PH_PAYLOAD, sld_pkg::PH_CHECK};
   assign take        = in_valid && (!emits || out_free);
   assign count_next  = count_ff + 16'd1;
   assign length_full = {in_byte, length_ff[sld_pkg::BYTE_WIDTH-1:0]};

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            sld_pkg::PH_HUNT2: begin
               if (in_byte == sync_second) begin
                  phase_in = sld_pkg::PH_LEN_LO;
               end else if (in_byte == sync_first) begin
                  phase_in = sld_pkg::PH_HUNT2;
               end else begin
                  phase_in = sld_pkg::PH_HUNT1;
               end
            end
            sld_pkg::PH_LEN_LO: begin
               phase_in = sld_pkg::PH_LEN_HI;
            end
            sld_pkg::PH_LEN_HI: begin
               phase_in = (length_full == '0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
            end
            sld_pkg::PH_PAYLOAD: begin
               phase_in = (count_next == length_ff) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
            end
            sld_pkg::PH_CHECK: begin
               phase_in = sld_pkg::PH_HUNT1;
            end
            default: begin
               phase_in = (in_byte == sync_first) ? sld_pkg::PH_HUNT2 : sld_pkg::PH_HUNT1;
            end
         endcase
      end
   end

   // Datapath and result.
   always_comb begin
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      push.load                 = take && emits;
      push.result.out_byte      = in_byte;
      push.result.payload_index = count_ff;
      push.result.frame_end     = 1'b0;
      push.result.frame_ok      = 1'b0;
      case (phase_ff)
         sld_pkg::PH_HUNT2: begin
            if (take && (in_byte == sync_second)) begin
               sum_in = in_byte;
            end
         end
         sld_pkg::PH_LEN_LO: begin
            if (take) begin
               length_in = {{(sld_pkg::INDEX_WIDTH-sld_pkg::BYTE_WIDTH){1'b0}}, in_byte};
               sum_in    = sum_ff + in_byte;
            end
         end
         sld_pkg::PH_LEN_HI: begin
            if (take) begin
               length_in = length_full;
               count_in  = '0;
               sum_in    = sum_ff + in_byte;
            end
         end
         sld_pkg::PH_PAYLOAD: begin
            if (take) begin
               count_in = count_next;
               sum_in   = sum_ff + in_byte;
            end
         end
         sld_pkg::PH_CHECK: begin
            push.result.payload_index = length_ff;
            push.result.frame_end     = 1'b1;
            push.result.frame_ok      = (~sum_ff == in_byte);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sld_pkg::PH_HUNT1;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

>>> design/sld_out_reg.sv
module sld_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  sld_pkg::result_push_type   push,
   input  logic                       rsp_ready,
   output logic                       out_free,
   output logic                       rsp_valid,
   output sld_pkg::result_type        result
);

   logic                 valid_ff, valid_in;
   sld_pkg::result_type  result_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push.load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.load) begin
         result_ff <= push.result;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

>>> design/sync_length_checksum_deframer.sv
// An accepted item waits in the input register until the parser takes it, and its result
// is then held in the result register; header bytes and bytes outside a frame give none.
// Throughput: one item per cycle, stalled by a full result register that is not read.
// Reset (synchronous, active high) returns the parser to the sync hunt, empties the input
// and result registers and restores the sync pair to 5A 83.
module sync_length_checksum_deframer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sld_pkg::BYTE_WIDTH-1:0]        req_in_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sld_pkg::BYTE_WIDTH-1:0]        rsp_out_byte,
   output logic [sld_pkg::INDEX_WIDTH-1:0]       rsp_payload_index,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_frame_ok,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sld_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sld_pkg::BYTE_WIDTH-1:0]        csr_data
);

   logic                              in_valid_ff, in_valid_in;
   logic [sld_pkg::BYTE_WIDTH-1:0]    in_byte_ff;
   logic [sld_pkg::BYTE_WIDTH-1:0]    sync_first_ff, sync_first_in;
   logic [sld_pkg::BYTE_WIDTH-1:0]    sync_second_ff, sync_second_in;
   logic                              take;
   logic                              out_free;
   sld_pkg::result_push_type          push;
   sld_pkg::result_type               result;

   assign csr_ready = 1'b1;
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid) begin
         case (csr_index)
            sld_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_data;
            sld_pkg::CSR_SYNC_SECOND: sync_second_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         sync_first_ff  <= sld_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= sld_pkg::SYNC_SECOND_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   sld_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .in_valid    (in_valid_ff),
      .in_byte     (in_byte_ff),
      .out_free    (out_free),
      .take        (take),
      .push        (push)
   );

   sld_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_ready (rsp_ready),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_out_byte      = result.out_byte;
   assign rsp_payload_index = result.payload_index;
   assign rsp_frame_end     = result.frame_end;
   assign rsp_frame_ok      = result.frame_ok;

endmodule

>>> design/sld_checker.sv
module sld_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [sld_pkg::BYTE_WIDTH-1:0]        rsp_out_byte,
   input logic [sld_pkg::INDEX_WIDTH-1:0]       rsp_payload_index,
   input logic                                  rsp_frame_end,
   input logic                                  rsp_frame_ok
);

   // A stalled result item holds its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_payload_index) && $stable(rsp_frame_end) && $stable(rsp_frame_ok))
      else $error("result item changed while stalled");

   // Payload items never carry a pass flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> !rsp_frame_ok)
      else $error("pass flag on a payload item");

   // Back-to-back payload items belong to one frame and count up by one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_frame_end) ##1 (rsp_valid && !rsp_frame_end)
         |-> rsp_payload_index == $past(rsp_payload_index) + 16'd1)
      else $error("payload index skipped");

   // Reset leaves the block empty and ready for an item.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind sync_length_checksum_deframer sld_checker u_sld_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_payload_index (rsp_payload_index),
   .rsp_frame_end     (rsp_frame_end),
   .rsp_frame_ok      (rsp_frame_ok)
);

>>> dv/tb_sync_length_checksum_deframer.sv
`timescale 1ns / 100ps

module tb_sync_length_checksum_deframer;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [sld_pkg::BYTE_WIDTH-1:0]      req_in_byte = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [sld_pkg::BYTE_WIDTH-1:0]      rsp_out_byte;
   logic [sld_pkg::INDEX_WIDTH-1:0]     rsp_payload_index;
   logic                                rsp_frame_end;
   logic                                rsp_frame_ok;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [sld_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [sld_pkg::BYTE_WIDTH-1:0]      csr_data = '0;

   sync_length_checksum_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_payload_index(rsp_payload_index),
      .rsp_frame_end(rsp_frame_end),
      .rsp_frame_ok(rsp_frame_ok),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Deframer state as the testbench sees it.
   logic [sld_pkg::BYTE_WIDTH-1:0]  sync_first_cfg = sld_pkg::SYNC_FIRST_RESET;
   logic [sld_pkg::BYTE_WIDTH-1:0]  sync_second_cfg = sld_pkg::SYNC_SECOND_RESET;
   sld_pkg::phase_type              parse_phase = sld_pkg::PH_HUNT1;
   logic [sld_pkg::INDEX_WIDTH-1:0] frame_len = '0;
   logic [sld_pkg::INDEX_WIDTH-1:0] bytes_in_frame = '0;
   logic [sld_pkg::BYTE_WIDTH-1:0]  frame_sum = '0;

   logic [sld_pkg::BYTE_WIDTH-1:0] pending_bytes[$];
   sld_pkg::result_type            expected_results[$];

   int  items_queued = 0;
   int  items_accepted = 0;
   int  results_checked = 0;
   int  frames_closed = 0;
   int  frames_rejected = 0;
   int  registers_written = 0;
   int  mismatches = 0;
   int  send_gap = 0;
   int  take_gap = 0;
   bit  idle_enable = 1'b1;

   function automatic void deframe_byte(input logic [sld_pkg::BYTE_WIDTH-1:0] b);
      sld_pkg::result_type r;
      case (parse_phase)
         sld_pkg::PH_HUNT2: begin
            if (b == sync_second_cfg) begin
               frame_sum = b;
               parse_phase = sld_pkg::PH_LEN_LO;
            end else if (b == sync_first_cfg) begin
               parse_phase = sld_pkg::PH_HUNT2;
            end else begin
               parse_phase = sld_pkg::PH_HUNT1;
            end
         end
         sld_pkg::PH_LEN_LO: begin
            frame_len = {8'h00, b};
            frame_sum = frame_sum + b;
            parse_phase = sld_pkg::PH_LEN_HI;
         end
         sld_pkg::PH_LEN_HI: begin
            frame_len[15:8] = b;
            frame_sum = frame_sum + b;
            bytes_in_frame = '0;
            parse_phase = (frame_len == '0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
         end
         sld_pkg::PH_PAYLOAD: begin
            r.out_byte = b;
            r.payload_index = bytes_in_frame;
            r.frame_end = 1'b0;
            r.frame_ok = 1'b0;
            expected_results.push_back(r);
            frame_sum = frame_sum + b;
            bytes_in_frame = bytes_in_frame + 1'b1;
            if (bytes_in_frame == frame_len) begin
               parse_phase = sld_pkg::PH_CHECK;
            end
         end
         sld_pkg::PH_CHECK: begin
            r.out_byte = b;
            r.payload_index = frame_len;
            r.frame_end = 1'b1;
            r.frame_ok = (~frame_sum == b);
            expected_results.push_back(r);
            parse_phase = sld_pkg::PH_HUNT1;
         end
         default: begin
            parse_phase = (b == sync_first_cfg) ? sld_pkg::PH_HUNT2 : sld_pkg::PH_HUNT1;
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%t ERROR: %s", $realtime, msg);
      end
   endfunction

   function automatic void queue_byte(input logic [sld_pkg::BYTE_WIDTH-1:0] b);
      pending_bytes.push_back(b);
      items_queued++;
   endfunction

   function automatic logic [sld_pkg::BYTE_WIDTH-1:0] pick_other(
         input logic [sld_pkg::BYTE_WIDTH-1:0] a,
         input logic [sld_pkg::BYTE_WIDTH-1:0] c);
      logic [sld_pkg::BYTE_WIDTH-1:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == a || v == c);
      return v;
   endfunction

   // A complete frame under the current sync pair; a non-zero spoil corrupts the checksum.
   function automatic void queue_frame(input logic [sld_pkg::INDEX_WIDTH-1:0] len,
                                       input logic [sld_pkg::BYTE_WIDTH-1:0] spoil);
      logic [sld_pkg::BYTE_WIDTH-1:0] sum;
      logic [sld_pkg::BYTE_WIDTH-1:0] data;
      sum = sync_second_cfg + len[7:0] + len[15:8];
      queue_byte(sync_first_cfg);
      queue_byte(sync_second_cfg);
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
      for (int i = 0; i < int'(len); i++) begin
         data = 8'($urandom_range(0, 255));
         sum = sum + data;
         queue_byte(data);
      end
      queue_byte(~sum ^ spoil);
   endfunction

   task automatic queue_traffic(input int count);
      int stop;
      int pick;
      int len;
      stop = items_queued + count;
      while (items_queued < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 48);
            queue_frame(16'(len), 8'h00);
         end else if (pick < 72) begin
            queue_frame(16'($urandom_range(0, 12)), 8'($urandom_range(1, 255)));
         end else if (pick < 82 || (pick < 94 && sync_first_cfg == sync_second_cfg)) begin
            repeat ($urandom_range(1, 4)) queue_byte(pick_other(sync_first_cfg, sync_first_cfg));
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 3)) queue_byte(sync_first_cfg);
            queue_byte(pick_other(sync_first_cfg, sync_second_cfg));
         end else begin
            // A frame cut short: its tail is taken from whatever follows.
            len = $urandom_range(1, 6);
            queue_byte(sync_first_cfg);
            queue_byte(sync_second_cfg);
            queue_byte(8'(len));
            queue_byte(8'h00);
            repeat ($urandom_range(0, len - 1)) queue_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic write_register(input logic [sld_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [sld_pkg::BYTE_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sld_pkg::CSR_SYNC_FIRST) begin
         sync_first_cfg = data;
      end else if (idx == sld_pkg::CSR_SYNC_SECOND) begin
         sync_second_cfg = data;
      end
      registers_written++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (items_accepted != items_queued || expected_results.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic                           next_valid;
      logic [sld_pkg::BYTE_WIDTH-1:0] next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_byte = req_in_byte;
         if (req_valid && req_ready) begin
            deframe_byte(req_in_byte);
            items_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (idle_enable && $urandom_range(0, 99) < 12) begin
               send_gap = $urandom_range(1, 17) - 1;
            end else if (pending_bytes.size() > 0) begin
               next_byte = pending_bytes.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_in_byte <= next_byte;
      end
   end

   always @(posedge clock) begin
      logic                next_ready;
      sld_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("unexpected item: byte %02h index %0d end %b ok %b",
                  rsp_out_byte, rsp_payload_index, rsp_frame_end, rsp_frame_ok));
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (want.frame_end) begin
                  frames_closed++;
                  if (!want.frame_ok) begin
                     frames_rejected++;
                  end
               end
               if (rsp_out_byte !== want.out_byte
                     || rsp_payload_index !== want.payload_index
                     || rsp_frame_end !== want.frame_end
                     || rsp_frame_ok !== want.frame_ok) begin
                  note_mismatch($sformatf({"expected byte %02h index %0d end %b ok %b, ",
                     "got byte %02h index %0d end %b ok %b"},
                     want.out_byte, want.payload_index, want.frame_end, want.frame_ok,
                     rsp_out_byte, rsp_payload_index, rsp_frame_end, rsp_frame_ok));
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            next_ready = 1'b0;
         end else if (idle_enable && $urandom_range(0, 99) < 12) begin
            take_gap = $urandom_range(1, 17) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ready <= next_ready;
      end
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [sld_pkg::BYTE_WIDTH-1:0] pair_value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(sync_first_cfg);
      queue_frame(16'd0, 8'h00);
      queue_byte(sync_first_cfg);
      queue_byte(8'h11);
      queue_frame(16'd2, 8'h00);
      queue_frame(16'd0, 8'h5C);
      queue_byte(sync_first_cfg);
      queue_byte(sync_first_cfg);
      queue_byte(8'h11);
      queue_traffic(50);
      wait_drained();

      write_register(sld_pkg::CSR_SYNC_FIRST, 8'h00);
      write_register(sld_pkg::CSR_SYNC_SECOND, 8'hFF);
      queue_frame(16'h0105, 8'h00);
      queue_traffic(70);
      wait_drained();

      idle_enable = 1'b0;
      write_register(sld_pkg::CSR_SYNC_FIRST, 8'hFF);
      write_register(sld_pkg::CSR_SYNC_SECOND, 8'h00);
      queue_traffic(100);
      wait_drained();

      idle_enable = 1'b1;
      pair_value = 8'($urandom_range(0, 255));
      write_register(sld_pkg::CSR_SYNC_FIRST, pair_value);
      write_register(sld_pkg::CSR_SYNC_SECOND, pair_value);
      write_register(sld_pkg::CSR_SYNC_SECOND + 8'($urandom_range(1, 254)),
                     8'($urandom_range(0, 255)));
      queue_traffic(100);
      wait_drained();

      pair_value = 8'($urandom_range(0, 255));
      write_register(sld_pkg::CSR_SYNC_FIRST, pair_value);
      write_register(sld_pkg::CSR_SYNC_SECOND, pick_other(pair_value, pair_value));
      queue_traffic(100);
      wait_drained();

      idle_enable = 1'b0;
      write_register(sld_pkg::CSR_SYNC_FIRST, sld_pkg::SYNC_FIRST_RESET);
      write_register(sld_pkg::CSR_SYNC_SECOND, sld_pkg::SYNC_SECOND_RESET);
      queue_traffic(100);
      wait_drained();

      $display("Sent %0d bytes under six sync settings with %0d register writes.",
         items_accepted, registers_written);
      $display("Checked %0d results: %0d frames closed, %0d with a bad checksum.",
         results_checked, frames_closed, frames_rejected);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/sld_pkg.sv
design/sld_parser.sv
design/sld_out_reg.sv
design/sync_length_checksum_deframer.sv
design/sld_checker.sv
dv/tb_sync_length_checksum_deframer.sv
